@@ hw/rtl/lph_pkg.sv @@
// Shared types and codes for the linear-probing hash table.
// Request/result structs, operation, status and slot-mark codes, sequencer states.
// No dependencies.
`default_nettype none

package lph_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned KEY_W     = 31;
  localparam int unsigned SLOT_W    = 4;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_e_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_SCALE,
    ST_HOME,
    ST_PROBE,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    func_e_t            func;
    logic [KEY_W-1:0]   key;
  } req_t;

  typedef struct packed {
    status_e_t          status;
    logic [SLOT_W-1:0]  slot;
  } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/linear_probe_hash_table.sv @@
// Open-addressing hash table, linear probing with tombstones.
// Depends on lph_pkg (request/result words, codes, states).
`default_nettype none

// A request word is taken when start is high and busy is low; its result word appears
// on rsp for exactly one cycle with done high and must be taken then. After accept
// the block is busy in the hash state and then probes 1..SLOTS slots, reading the
// slot memories through one read port, one slot per cycle. When SLOTS is not a power
// of two the home slot also passes the states ST_SCALE and ST_HOME: the key is
// multiplied by a rounded-up reciprocal of SLOTS and the quotient multiplied back,
// on one shared multiplier. Clear sweeps the mark memory one slot per cycle. After
// reset the same sweep runs with busy high before the first word is taken.
module linear_probe_hash_table #(
  parameter int unsigned SLOTS = lph_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire lph_pkg::req_t req,
  output logic               done,
  output lph_pkg::rsp_t      rsp
);

  import lph_pkg::*;

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam bit          POW2   = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);
  localparam int unsigned PROD_W = KEY_W + 32;
  localparam int unsigned SHIFT  = KEY_W + IDX_W;
  // ceil(2^SHIFT / SLOTS): exact quotient for every key below 2^KEY_W
  localparam logic [31:0] RECIP   =
    32'((((64'd1 << SHIFT) + 64'(SLOTS - 1)) / 64'(SLOTS)));
  localparam logic [31:0] SLOTS_M = 32'(SLOTS);

  // slot storage
  mark_e_t          marks_mem [SLOTS];
  logic [KEY_W-1:0] keys_mem  [SLOTS];

  state_t           state, state_next;
  req_t             req_q;
  logic [IDX_W-1:0] pos, pos_next;
  logic [IDX_W-1:0] probes, probes_next;
  logic [PROD_W-1:0] prod, prod_next;
  logic             done_next;
  rsp_t             rsp_next;

  logic [IDX_W-1:0] rd_addr;
  mark_e_t          rd_mark;
  logic [KEY_W-1:0] rd_key;
  logic             mark_we;
  mark_e_t          mark_wd;
  logic             key_we;

  logic [IDX_W-1:0]  pos_inc;
  logic [KEY_W-1:0]  quot, key_rem;
  logic [31:0]       mul_a;
  logic [KEY_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod_mul;
  logic [IDX_W-1:0]  home;
  logic              key_hit, last_probe;

  always_comb begin
    pos_inc    = (pos == LAST) ? '0 : pos + IDX_W'(1);
    quot       = KEY_W'(prod >> SHIFT);
    // shared multiplier: key times reciprocal, then quotient times SLOTS
    mul_a      = (state == ST_HASH) ? RECIP : SLOTS_M;
    mul_b      = (state == ST_HASH) ? req_q.key : quot;
    prod_mul   = PROD_W'(mul_a) * PROD_W'(mul_b);
    key_rem    = req_q.key - prod[KEY_W-1:0];
    home       = POW2 ? req_q.key[IDX_W-1:0] : key_rem[IDX_W-1:0];
    key_hit    = (rd_mark == MARK_USED) && (rd_key == req_q.key);
    last_probe = (probes == LAST);
  end

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    probes_next = probes;
    prod_next   = prod;
    rd_addr     = pos_inc;   // prefetch the next slot while probing
    mark_we     = 1'b0;
    mark_wd     = MARK_EMPTY;
    key_we      = 1'b0;
    done_next   = 1'b0;
    rsp_next.status = STAT_OK;
    rsp_next.slot   = '0;
    busy        = (state != ST_IDLE);

    unique case (state)
      ST_INIT: begin
        mark_we = 1'b1;
        if (pos == LAST) begin
          pos_next   = '0;
          state_next = ST_IDLE;
        end else begin
          pos_next = pos + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (req.func == FUNC_CLEAR) begin
            pos_next   = '0;
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (POW2) begin
          rd_addr     = home;
          pos_next    = home;
          probes_next = '0;
          state_next  = ST_PROBE;
        end else begin
          prod_next  = prod_mul;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        prod_next  = prod_mul;
        state_next = ST_HOME;
      end
      ST_HOME: begin
        rd_addr     = home;
        pos_next    = home;
        probes_next = '0;
        state_next  = ST_PROBE;
      end
      ST_PROBE: begin
        if (req_q.func == FUNC_INSERT) begin
          priority if (rd_mark != MARK_USED) begin
            key_we        = 1'b1;
            mark_we       = 1'b1;
            mark_wd       = MARK_USED;
            done_next     = 1'b1;
            rsp_next.slot = SLOT_W'(pos);
            state_next    = ST_IDLE;
          end else if (last_probe) begin
            done_next       = 1'b1;
            rsp_next.status = STAT_FULL;
            state_next      = ST_IDLE;
          end else begin
            pos_next    = pos_inc;
            probes_next = probes + IDX_W'(1);
          end
        end else begin
          priority if (rd_mark == MARK_EMPTY) begin
            done_next       = 1'b1;
            rsp_next.status = STAT_MISS;
            state_next      = ST_IDLE;
          end else if (key_hit) begin
            if (req_q.func == FUNC_REMOVE) begin
              mark_we = 1'b1;
              mark_wd = MARK_GONE;
            end
            done_next     = 1'b1;
            rsp_next.slot = SLOT_W'(pos);
            state_next    = ST_IDLE;
          end else if (last_probe) begin
            done_next       = 1'b1;
            rsp_next.status = STAT_MISS;
            state_next      = ST_IDLE;
          end else begin
            pos_next    = pos_inc;
            probes_next = probes + IDX_W'(1);
          end
        end
      end
      ST_CLEAR: begin
        mark_we = 1'b1;
        if (pos == LAST) begin
          pos_next   = '0;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          pos_next = pos + IDX_W'(1);
        end
      end
      default: begin
        state_next = ST_INIT;
        pos_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      pos   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    probes <= probes_next;
    prod   <= prod_next;
    rsp    <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks_mem[pos] <= mark_wd;
    end
    rd_mark <= marks_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      keys_mem[pos] <= req_q.key;
    end
    rd_key <= keys_mem[rd_addr];
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result strobe while not idle");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_PROBE || $past(state) == ST_CLEAR))
    else $error("result strobe without a probe or clear");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(mark_we || key_we))
    else $error("slot memory written while idle");

endmodule

`default_nettype wire

@@ tb/lph_result_checker.sv @@
// Result checker for the linear-probing hash table: watches the request and result
// channels, keeps its own copy of the table and compares every result word.
// Depends on lph_pkg.
`timescale 1ns / 100ps

module lph_result_checker #(
  parameter int unsigned SLOTS = lph_pkg::SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      busy,
  input  lph_pkg::req_t  req,
  input  wire logic      done,
  input  lph_pkg::rsp_t  rsp,
  output int             errors,
  output int             pending
);
  import lph_pkg::*;

  logic [KEY_W-1:0] table_key [SLOTS];
  mark_e_t          table_mark [SLOTS];
  rsp_t             expected_rsp_q [$];
  int               mismatch_count = 0;
  int               waiting_count = 0;

  assign errors  = mismatch_count;
  assign pending = waiting_count;

  // Applies one request word to the shadow table and returns the result word it yields.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        res;
    int unsigned pos;
    bit          hit;
    bit          stop;
    res.status = STAT_OK;
    res.slot   = '0;
    pos  = r.key % SLOTS;
    hit  = 1'b0;
    stop = 1'b0;
    case (r.func)
      FUNC_INSERT: begin
        // first empty or tombstoned slot wins; duplicates are stored again
        for (int n = 0; n < SLOTS && !hit; n++) begin
          if (table_mark[pos] != MARK_USED) begin
            table_key[pos]  = r.key;
            table_mark[pos] = MARK_USED;
            res.slot = pos[SLOT_W-1:0];
            hit = 1'b1;
          end else begin
            pos = (pos + 1) % SLOTS;
          end
        end
        if (!hit) res.status = STAT_FULL;
      end
      FUNC_REMOVE, FUNC_SEARCH: begin
        // tombstones are skipped, an empty slot ends the probe
        for (int n = 0; n < SLOTS && !hit && !stop; n++) begin
          if (table_mark[pos] == MARK_EMPTY) begin
            stop = 1'b1;
          end else if (table_mark[pos] == MARK_USED && table_key[pos] == r.key) begin
            hit = 1'b1;
          end else begin
            pos = (pos + 1) % SLOTS;
          end
        end
        if (hit) begin
          res.slot = pos[SLOT_W-1:0];
          if (r.func == FUNC_REMOVE) table_mark[pos] = MARK_GONE;
        end else begin
          res.status = STAT_MISS;
        end
      end
      default: begin
        foreach (table_mark[i]) table_mark[i] = MARK_EMPTY;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t exp_word;
    if (rst) begin
      foreach (table_mark[i]) table_mark[i] = MARK_EMPTY;
      expected_rsp_q.delete();
    end else begin
      if (start === 1'b1 && busy === 1'b0)
        expected_rsp_q.push_back(apply_request(req));
      if (done === 1'b1) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result word with nothing expected: status %0d slot %0d",
                 rsp.status, rsp.slot);
          mismatch_count++;
        end else begin
          exp_word = expected_rsp_q.pop_front();
          if (rsp.status !== exp_word.status) begin
            $error("status mismatch: expected %0d, got %0d", exp_word.status, rsp.status);
            mismatch_count++;
          end
          if (rsp.slot !== exp_word.slot) begin
            $error("slot mismatch: expected %0d, got %0d", exp_word.slot, rsp.slot);
            mismatch_count++;
          end
        end
      end
    end
    waiting_count = expected_rsp_q.size();
  end

endmodule

@@ tb/linear_probe_hash_table_tb.sv @@
// Top of the hash table testbench: clock, reset, request stimulus and verdict.
// Depends on lph_pkg, linear_probe_hash_table and lph_result_checker.
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
  import lph_pkg::*;

  localparam int unsigned SLOTS  = SLOTS_DEF;
  localparam int          N_WORDS = 1250;
  localparam int          PHASE_LEN = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;
  int   errors;
  int   pending;

  int               idle_pct = 36;
  int               words_sent = 0;
  logic [KEY_W-1:0] key_pool [16];
  int               pool_len = 1;

  always #5 clk = ~clk;

  linear_probe_hash_table #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  lph_result_checker #(.SLOTS(SLOTS)) result_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .errors(errors), .pending(pending)
  );

  // Random 31-bit key; half of them crowd into the first few home slots.
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    if ($urandom_range(1) == 1) k[3:0] = 4'($urandom_range(3));
    return k;
  endfunction

  // Presents one request word and returns at the edge that takes it.
  task automatic send_word(input func_e_t f, input logic [KEY_W-1:0] k);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    req.func <= f;
    req.key  <= k;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // at least one edge first, so the word just taken is already counted
  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int      ins_w;
    int      rem_w;
    int      r;
    func_e_t f;
    logic [KEY_W-1:0] k;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, collisions, wraparound, tombstones, full table
    send_word(FUNC_SEARCH, 31'd0);
    send_word(FUNC_REMOVE, 31'h7FFF_FFFF);
    send_word(FUNC_INSERT, 31'd0);
    send_word(FUNC_INSERT, 31'h7FFF_FFFF);
    send_word(FUNC_INSERT, 31'd16);
    send_word(FUNC_INSERT, 31'd31);        // home 15 taken, wraps to slot 2
    send_word(FUNC_INSERT, 31'd0);         // duplicate
    send_word(FUNC_SEARCH, 31'd16);
    send_word(FUNC_REMOVE, 31'd0);
    send_word(FUNC_SEARCH, 31'd0);         // probes past the tombstone
    send_word(FUNC_SEARCH, 31'd31);
    send_word(FUNC_INSERT, 31'd32);        // reuses the tombstone
    for (int i = 0; i < 11; i++) send_word(FUNC_INSERT, random_key());
    send_word(FUNC_INSERT, 31'h2AAA_AAAA); // table full
    send_word(FUNC_SEARCH, 31'h5555_5555); // no empty slot, full probe
    send_word(FUNC_REMOVE, 31'h5555_5554);
    send_word(FUNC_CLEAR, 31'h7FFF_FFFF);
    send_word(FUNC_SEARCH, 31'd16);

    for (int phase = 0; words_sent < N_WORDS; phase++) begin
      idle_pct = (phase == 4 || phase == 5) ? 0 : 36;
      ins_w = $urandom_range(25, 65);
      rem_w = $urandom_range(5, 25);
      pool_len = $urandom_range(3, 16);
      foreach (key_pool[i]) key_pool[i] = random_key();
      for (int i = 0; i < PHASE_LEN; i++) begin
        r = $urandom_range(99);
        if (r < 2) f = FUNC_CLEAR;
        else if (r < 2 + ins_w) f = FUNC_INSERT;
        else if (r < 2 + ins_w + rem_w) f = FUNC_REMOVE;
        else f = FUNC_SEARCH;
        k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_len - 1)]
                                      : random_key();
        send_word(f, k);
      end
      if (phase == 8) wait_results_drained();
    end

    wait_results_drained();
    repeat (SLOTS + 8) @(posedge clk);
    if (pending != 0) $error("%0d expected words never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
